/* rtl/core/ltt_pkg.sv */
package ltt_pkg;

    // Width of the internal line counter; it saturates at all ones.
    localparam int LINE_BITS  = 24;
    // Width of the line number on the result port.
    localparam int LINE_OUT_W = 24;

    // Result queue between the lexer and the result port.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [LINE_BITS-1:0]  t_line;
    typedef logic [LINE_OUT_W-1:0] t_line_out;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_COMMENT = 4'd1,
        M_NAME    = 4'd2,
        M_INT     = 4'd3,
        M_DOT     = 4'd4,
        M_FRAC    = 4'd5,
        M_EXPE    = 4'd6,
        M_EXPS    = 4'd7,
        M_EXPD    = 4'd8,
        M_REL     = 4'd9,
        M_DONE    = 4'd10
    } t_mode;

    // Token kinds.
    localparam logic [3:0] K_NUMBER = 4'd0;
    localparam logic [3:0] K_NAME   = 4'd1;
    localparam logic [3:0] K_PLUS   = 4'd2;
    localparam logic [3:0] K_MINUS  = 4'd3;
    localparam logic [3:0] K_STAR   = 4'd4;
    localparam logic [3:0] K_CARET  = 4'd5;
    localparam logic [3:0] K_SLASH  = 4'd6;
    localparam logic [3:0] K_LE     = 4'd7;
    localparam logic [3:0] K_GE     = 4'd8;
    localparam logic [3:0] K_EQ     = 4'd9;
    localparam logic [3:0] K_LBR    = 4'd10;
    localparam logic [3:0] K_RBR    = 4'd11;
    localparam logic [3:0] K_COLON  = 4'd12;
    localparam logic [3:0] K_END    = 4'd13;

    // Error codes.
    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_UNEXP = 2'd1;
    localparam logic [1:0] E_EXPO  = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       first;
        logic       last;
        t_line_out  line;
        logic       fol;
        logic [1:0] err;
    } t_result;

    // Up to two results that the lexer hands to the queue in one cycle.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_qwr;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_name_begin(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic f_is_name_cont(input logic [7:0] c);
        return f_is_name_begin(c) || f_is_digit(c) || (c == CH_DOT);
    endfunction

endpackage

/* rtl/core/lp_text_tokenizer.sv */
// A result is queued as the byte that completes it is accepted and reaches the ports at
// the queue head; a token byte is held until the next byte shows whether it ends the
// token. Throughput: one byte and, while pop is high, one result per cycle; a byte that
// gives two results is absorbed by the four-entry queue, which stops input when two free
// entries are not left. Reset is synchronous and active low: it empties the queue, sets
// the line count to one and returns the lexer to the idle state between tokens.
module lp_text_tokenizer
    import ltt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Text side.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_text,
    // Result side.
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_token_kind,
    output logic [7:0]  o_tok_char,
    output logic        o_token_first,
    output logic        o_token_last,
    output logic [23:0] o_line_number,
    output logic        o_first_on_line,
    output logic [1:0]  o_error_code
);

    // The front end decides each byte as it is accepted and hands zero, one
    // or two results to the queue in the same cycle. The queue head drives
    // the result ports directly, so the two sides stall independently.
    t_qwr    w_wr;
    t_result w_head;
    logic    w_take;

    // An item is taken whenever the queue can absorb the worst case of two results.
    assign w_take = push && !full;

    ltt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_ch    (i_ch),
        .i_eot   (i_end_of_text),
        .o_wr    (w_wr)
    );

    ltt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_pop   (pop),
        .o_head  (w_head),
        .o_empty (empty),
        .o_full  (full)
    );

    // The head entry is unpacked onto the result ports.
    assign o_token_kind    = w_head.kind;
    assign o_tok_char      = w_head.ch;
    assign o_token_first   = w_head.first;
    assign o_token_last    = w_head.last;
    assign o_line_number   = w_head.line;
    assign o_first_on_line = w_head.fol;
    assign o_error_code    = w_head.err;

endmodule

/* rtl/core/ltt_front.sv */
module ltt_front
    import ltt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_ch,
    input  logic       i_eot,
    output t_qwr       o_wr
);

    t_mode      r_mode,   n_mode;
    logic [7:0] r_hb,     n_hb;
    logic       r_hv,     n_hv;
    logic [3:0] r_hk,     n_hk;
    logic       r_hf,     n_hf;
    t_line      r_line,   n_line;
    logic       r_lsf,    n_lsf;
    logic       r_failed, n_failed;

    t_result    v_res [2];
    logic [1:0] v_n;
    logic       v_idle;
    logic       v_is_e;

    function automatic t_result f_res(input logic [3:0] kind, input logic [7:0] c,
                                      input logic first, input logic last,
                                      input logic fol, input logic [1:0] err,
                                      input t_line line);
        t_result r;
        r.kind  = kind;
        r.ch    = c;
        r.first = first;
        r.last  = last;
        r.line  = t_line_out'(line);
        r.fol   = fol;
        r.err   = err;
        return r;
    endfunction

    // One byte is decided per cycle. Results are collected in order; a result
    // that closes a token clears the first-on-line flag for the ones after it.
    always_comb begin
        n_mode   = r_mode;
        n_hb     = r_hb;
        n_hv     = r_hv;
        n_hk     = r_hk;
        n_hf     = r_hf;
        n_line   = r_line;
        n_lsf    = r_lsf;
        n_failed = r_failed;
        v_res[0] = '0;
        v_res[1] = '0;
        v_n      = 2'd0;
        v_idle   = 1'b0;
        v_is_e   = (i_ch == CH_LOW_E) || (i_ch == CH_UP_E);

        if (i_take && !r_failed && (r_mode != M_DONE)) begin
            if (i_eot) begin
                case (r_mode)
                    M_EXPE, M_EXPS: begin
                        v_res[v_n[0]] = f_res(K_NUMBER, CH_NUL, 1'b0, 1'b0, n_lsf, E_EXPO,
                                              r_line);
                        v_n      = v_n + 2'd1;
                        n_hv     = 1'b0;
                        n_failed = 1'b1;
                        n_mode   = M_IDLE;
                    end
                    M_DOT: begin
                        v_res[v_n[0]] = f_res(K_NUMBER, CH_DOT, 1'b0, 1'b0, n_lsf, E_UNEXP,
                                              r_line);
                        v_n      = v_n + 2'd1;
                        n_hv     = 1'b0;
                        n_failed = 1'b1;
                        n_mode   = M_IDLE;
                    end
                    default: begin
                        if (r_hv) begin
                            v_res[v_n[0]] = f_res(r_hk, r_hb, r_hf, 1'b1, n_lsf, E_NONE,
                                                  r_line);
                            v_n   = v_n + 2'd1;
                            n_lsf = 1'b0;
                        end
                        n_hv   = 1'b0;
                        n_mode = M_IDLE;
                    end
                endcase
                if (!n_failed) begin
                    v_res[v_n[0]] = f_res(K_END, CH_NUL, 1'b1, 1'b1, 1'b1, E_NONE, r_line);
                    v_n    = v_n + 2'd1;
                    n_hv   = 1'b0;
                    n_mode = M_DONE;
                end
            end else begin
                case (r_mode)
                    M_COMMENT: begin
                        if (i_ch == CH_NL) begin
                            if (r_line != {LINE_BITS{1'b1}}) begin
                                n_line = r_line + LINE_BITS'(1);
                            end
                            n_lsf  = 1'b1;
                            n_mode = M_IDLE;
                        end
                    end
                    M_NAME, M_INT, M_FRAC, M_EXPD, M_EXPE, M_EXPS, M_DOT: begin
                        // Extension of the current token: the held byte goes out
                        // marked as not last, and the new byte is held instead.
                        logic  ext;
                        t_mode ext_mode;
                        logic  bad;
                        ext      = 1'b0;
                        ext_mode = r_mode;
                        bad      = 1'b0;
                        case (r_mode)
                            M_NAME: begin
                                ext = f_is_name_cont(i_ch);
                            end
                            M_INT: begin
                                if (f_is_digit(i_ch)) begin
                                    ext = 1'b1;
                                end else if (i_ch == CH_DOT) begin
                                    ext = 1'b1; ext_mode = M_FRAC;
                                end else if (v_is_e) begin
                                    ext = 1'b1; ext_mode = M_EXPE;
                                end
                            end
                            M_FRAC: begin
                                if (f_is_digit(i_ch)) begin
                                    ext = 1'b1;
                                end else if (v_is_e) begin
                                    ext = 1'b1; ext_mode = M_EXPE;
                                end
                            end
                            M_EXPE: begin
                                if ((i_ch == CH_PLUS) || (i_ch == CH_MINUS)) begin
                                    ext = 1'b1; ext_mode = M_EXPS;
                                end else if (f_is_digit(i_ch)) begin
                                    ext = 1'b1; ext_mode = M_EXPD;
                                end else begin
                                    bad = 1'b1;
                                end
                            end
                            M_EXPS: begin
                                if (f_is_digit(i_ch)) begin
                                    ext = 1'b1; ext_mode = M_EXPD;
                                end else begin
                                    bad = 1'b1;
                                end
                            end
                            M_EXPD: begin
                                ext = f_is_digit(i_ch);
                            end
                            default: begin
                                // Leading dot: only a digit may follow.
                                if (f_is_digit(i_ch)) begin
                                    ext = 1'b1; ext_mode = M_FRAC;
                                end else begin
                                    bad = 1'b1;
                                end
                            end
                        endcase
                        if (ext) begin
                            if (r_hv) begin
                                v_res[v_n[0]] = f_res(r_hk, r_hb, r_hf, 1'b0, n_lsf, E_NONE,
                                                      r_line);
                                v_n = v_n + 2'd1;
                            end
                            n_hb   = i_ch;
                            n_hf   = 1'b0;
                            n_hv   = 1'b1;
                            n_mode = ext_mode;
                        end else if (bad) begin
                            v_res[v_n[0]] = f_res(K_NUMBER,
                                                  (r_mode == M_DOT) ? CH_DOT : i_ch,
                                                  1'b0, 1'b0, n_lsf,
                                                  (r_mode == M_DOT) ? E_UNEXP : E_EXPO,
                                                  r_line);
                            v_n      = v_n + 2'd1;
                            n_hv     = 1'b0;
                            n_failed = 1'b1;
                            n_mode   = M_IDLE;
                        end else begin
                            if (r_hv) begin
                                v_res[v_n[0]] = f_res(r_hk, r_hb, r_hf, 1'b1, n_lsf, E_NONE,
                                                      r_line);
                                v_n   = v_n + 2'd1;
                                n_lsf = 1'b0;
                            end
                            n_hv   = 1'b0;
                            n_mode = M_IDLE;
                            v_idle = 1'b1;
                        end
                    end
                    M_REL: begin
                        if (i_ch == CH_EQ) begin
                            v_res[0] = f_res(r_hk, r_hb, r_hf, 1'b0, r_lsf, E_NONE, r_line);
                            v_res[1] = f_res(r_hk, i_ch, 1'b0, 1'b1, r_lsf, E_NONE, r_line);
                            v_n      = 2'd2;
                            n_lsf    = 1'b0;
                            n_hv     = 1'b0;
                            n_mode   = M_IDLE;
                        end else begin
                            if (r_hv) begin
                                v_res[v_n[0]] = f_res(r_hk, r_hb, r_hf, 1'b1, n_lsf, E_NONE,
                                                      r_line);
                                v_n   = v_n + 2'd1;
                                n_lsf = 1'b0;
                            end
                            n_hv   = 1'b0;
                            n_mode = M_IDLE;
                            v_idle = 1'b1;
                        end
                    end
                    default: begin
                        n_hv   = 1'b0;
                        n_mode = M_IDLE;
                        v_idle = 1'b1;
                    end
                endcase

                // The byte starts afresh between tokens.
                if (v_idle) begin
                    case (i_ch)
                        CH_NL: begin
                            if (r_line != {LINE_BITS{1'b1}}) begin
                                n_line = r_line + LINE_BITS'(1);
                            end
                            n_lsf = 1'b1;
                        end
                        CH_CR, CH_SPACE, CH_TAB: begin
                        end
                        CH_BSL: begin
                            n_mode = M_COMMENT;
                        end
                        CH_PLUS, CH_MINUS, CH_STAR, CH_CARET, CH_SLASH, CH_EQ,
                        CH_LBR, CH_RBR, CH_COLON: begin
                            logic [3:0] k;
                            case (i_ch)
                                CH_PLUS:  k = K_PLUS;
                                CH_MINUS: k = K_MINUS;
                                CH_STAR:  k = K_STAR;
                                CH_CARET: k = K_CARET;
                                CH_SLASH: k = K_SLASH;
                                CH_EQ:    k = K_EQ;
                                CH_LBR:   k = K_LBR;
                                CH_RBR:   k = K_RBR;
                                default:  k = K_COLON;
                            endcase
                            v_res[v_n[0]] = f_res(k, i_ch, 1'b1, 1'b1, n_lsf, E_NONE, r_line);
                            v_n   = v_n + 2'd1;
                            n_lsf = 1'b0;
                        end
                        CH_LT: begin
                            n_hb = i_ch; n_hk = K_LE; n_hf = 1'b1; n_hv = 1'b1;
                            n_mode = M_REL;
                        end
                        CH_GT: begin
                            n_hb = i_ch; n_hk = K_GE; n_hf = 1'b1; n_hv = 1'b1;
                            n_mode = M_REL;
                        end
                        CH_DOT: begin
                            n_hb = i_ch; n_hk = K_NUMBER; n_hf = 1'b1; n_hv = 1'b1;
                            n_mode = M_DOT;
                        end
                        default: begin
                            if (f_is_digit(i_ch)) begin
                                n_hb = i_ch; n_hk = K_NUMBER; n_hf = 1'b1; n_hv = 1'b1;
                                n_mode = M_INT;
                            end else if (f_is_name_begin(i_ch)) begin
                                n_hb = i_ch; n_hk = K_NAME; n_hf = 1'b1; n_hv = 1'b1;
                                n_mode = M_NAME;
                            end else begin
                                v_res[v_n[0]] = f_res(K_NUMBER, i_ch, 1'b0, 1'b0, n_lsf,
                                                      E_UNEXP, r_line);
                                v_n      = v_n + 2'd1;
                                n_hv     = 1'b0;
                                n_failed = 1'b1;
                                n_mode   = M_IDLE;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        o_wr.n  = v_n;
        o_wr.r0 = v_res[0];
        o_wr.r1 = v_res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_hb     <= '0;
            r_hv     <= 1'b0;
            r_hk     <= '0;
            r_hf     <= 1'b0;
            r_line   <= LINE_BITS'(1);
            r_lsf    <= 1'b1;
            r_failed <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_hb     <= n_hb;
            r_hv     <= n_hv;
            r_hk     <= n_hk;
            r_hf     <= n_hf;
            r_line   <= n_line;
            r_lsf    <= n_lsf;
            r_failed <= n_failed;
        end
    end

endmodule

/* rtl/core/ltt_queue.sv */
module ltt_queue
    import ltt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qwr    i_wr,
    input  logic    i_pop,
    output t_result o_head,
    output logic    o_empty,
    output logic    o_full
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              v_pop;

    assign o_empty = (r_count == '0);
    // Full as soon as two more results might not fit.
    assign o_full  = (r_count > QCNT_W'(QDEPTH - 2));
    assign o_head  = r_mem[r_rd];
    assign v_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr + QPTR_W'(i_wr.n);
        n_rd    = r_rd + QPTR_W'(v_pop);
        n_count = r_count + QCNT_W'(i_wr.n) - QCNT_W'(v_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.n != 2'd0) begin
            r_mem[r_wr] <= i_wr.r0;
        end
        if (i_wr.n == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_wr.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/core/ltt_checker.sv */
module ltt_checker
    import ltt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  o_token_kind,
    input logic        o_token_first,
    input logic        o_token_last,
    input logic [23:0] o_line_number,
    input logic [1:0]  o_error_code
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results pending after reset");

    // An empty queue always has room for input.
    a_empty_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> !full)
        else $error("full while no result waits");

    // The end token is the last result ever given.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && (o_token_kind == K_END)) |=> empty)
        else $error("result after the end token");

    // An error result carries no token flags.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_error_code != E_NONE))
            |-> ((o_token_kind == K_NUMBER) && !o_token_first && !o_token_last))
        else $error("malformed error result");

    // Lines count from one.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_line_number != '0))
        else $error("line number zero");

endmodule

bind lp_text_tokenizer ltt_checker u_ltt_checker (.*);

/* dv/lp_text_tokenizer_test.sv */
`timescale 1ns / 1ps

module lp_text_tokenizer_test;

    import ltt_pkg::*;

    // Token ledger: a byte-level copy of the lexer that turns every accepted item into the
    // token results it must produce, and keeps them in order until the block hands them
    // out. The block is reset only once, so the ledger starts from the reset state.
    class token_ledger;
        t_result     tokens_due[$];
        int unsigned faults;

        t_mode       lex_state;
        logic [7:0]  held_ch;
        logic [3:0]  held_kind;
        logic        held_valid;
        logic        held_first;
        logic        at_line_start;
        logic        dead;
        t_line       line_cnt;

        function new();
            lex_state     = M_IDLE;
            held_ch       = '0;
            held_kind     = K_NUMBER;
            held_valid    = 1'b0;
            held_first    = 1'b0;
            at_line_start = 1'b1;
            dead          = 1'b0;
            line_cnt      = 1;
            faults        = 0;
        endfunction

        function int due();
            return tokens_due.size();
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function bit name_head(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
        endfunction

        function bit name_tail(logic [7:0] c);
            return name_head(c) || is_dec(c) || c == CH_DOT;
        endfunction

        function void queue_token(logic [3:0] kind, logic [7:0] c, logic first, logic last,
                                  logic fol, logic [1:0] code);
            t_result r;
            r.kind  = kind;
            r.ch    = c;
            r.first = first;
            r.last  = last;
            r.line  = t_line_out'(line_cnt);
            r.fol   = fol;
            r.err   = code;
            tokens_due.insert(tokens_due.size(), r);
        endfunction

        // A token byte; the line-start flag drops once a whole token has gone out.
        function void give(logic [3:0] kind, logic [7:0] c, logic first, logic last);
            queue_token(kind, c, first, last, at_line_start, E_NONE);
            if (last) begin
                at_line_start = 1'b0;
            end
        endfunction

        function void release_held();
            if (held_valid) begin
                give(held_kind, held_ch, held_first, 1'b1);
            end
            held_valid = 1'b0;
            lex_state  = M_IDLE;
        endfunction

        function void grow(logic [7:0] c, t_mode next);
            if (held_valid) begin
                give(held_kind, held_ch, held_first, 1'b0);
            end
            held_ch    = c;
            held_first = 1'b0;
            held_valid = 1'b1;
            lex_state  = next;
        endfunction

        function void start_held(logic [7:0] c, logic [3:0] kind, t_mode next);
            held_ch    = c;
            held_kind  = kind;
            held_first = 1'b1;
            held_valid = 1'b1;
            lex_state  = next;
        endfunction

        function void abort(logic [7:0] c, logic [1:0] code);
            queue_token(K_NUMBER, c, 1'b0, 1'b0, at_line_start, code);
            held_valid = 1'b0;
            dead       = 1'b1;
            lex_state  = M_IDLE;
        endfunction

        function void next_line();
            if (line_cnt != '1) begin
                line_cnt++;
            end
            at_line_start = 1'b1;
        endfunction

        // One accepted item.
        function void take_byte(logic [7:0] c, logic eot);
            bit fresh;
            bit is_e;
            is_e  = (c == CH_LOW_E) || (c == CH_UP_E);
            fresh = 1'b0;
            if (dead || lex_state == M_DONE) begin
                return;
            end
            if (eot) begin
                case (lex_state)
                    M_EXPE, M_EXPS: abort(CH_NUL, E_EXPO);
                    M_DOT:          abort(CH_DOT, E_UNEXP);
                    default:        release_held();
                endcase
                if (!dead) begin
                    queue_token(K_END, CH_NUL, 1'b1, 1'b1, 1'b1, E_NONE);
                    held_valid = 1'b0;
                    lex_state  = M_DONE;
                end
                return;
            end
            case (lex_state)
                M_COMMENT: begin
                    if (c == CH_NL) begin
                        next_line();
                        lex_state = M_IDLE;
                    end
                end
                M_NAME: begin
                    if (name_tail(c)) grow(c, M_NAME);
                    else begin
                        release_held();
                        fresh = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_dec(c)) grow(c, M_INT);
                    else if (c == CH_DOT) grow(c, M_FRAC);
                    else if (is_e) grow(c, M_EXPE);
                    else begin
                        release_held();
                        fresh = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_dec(c)) grow(c, M_FRAC);
                    else if (is_e) grow(c, M_EXPE);
                    else begin
                        release_held();
                        fresh = 1'b1;
                    end
                end
                M_EXPE: begin
                    if (c == CH_PLUS || c == CH_MINUS) grow(c, M_EXPS);
                    else if (is_dec(c)) grow(c, M_EXPD);
                    else abort(c, E_EXPO);
                end
                M_EXPS: begin
                    if (is_dec(c)) grow(c, M_EXPD);
                    else abort(c, E_EXPO);
                end
                M_EXPD: begin
                    if (is_dec(c)) grow(c, M_EXPD);
                    else begin
                        release_held();
                        fresh = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_dec(c)) grow(c, M_FRAC);
                    else abort(CH_DOT, E_UNEXP);
                end
                M_REL: begin
                    if (c == CH_EQ) begin
                        give(held_kind, held_ch, held_first, 1'b0);
                        give(held_kind, c, 1'b0, 1'b1);
                        held_valid = 1'b0;
                        lex_state  = M_IDLE;
                    end else begin
                        release_held();
                        fresh = 1'b1;
                    end
                end
                default: begin
                    held_valid = 1'b0;
                    lex_state  = M_IDLE;
                    fresh      = 1'b1;
                end
            endcase
            if (fresh) begin
                case (c)
                    CH_NL:                  next_line();
                    CH_CR, CH_SPACE, CH_TAB: ;
                    CH_BSL:                 lex_state = M_COMMENT;
                    CH_PLUS:                give(K_PLUS, c, 1'b1, 1'b1);
                    CH_MINUS:               give(K_MINUS, c, 1'b1, 1'b1);
                    CH_STAR:                give(K_STAR, c, 1'b1, 1'b1);
                    CH_CARET:               give(K_CARET, c, 1'b1, 1'b1);
                    CH_SLASH:               give(K_SLASH, c, 1'b1, 1'b1);
                    CH_EQ:                  give(K_EQ, c, 1'b1, 1'b1);
                    CH_LBR:                 give(K_LBR, c, 1'b1, 1'b1);
                    CH_RBR:                 give(K_RBR, c, 1'b1, 1'b1);
                    CH_COLON:               give(K_COLON, c, 1'b1, 1'b1);
                    CH_LT:                  start_held(c, K_LE, M_REL);
                    CH_GT:                  start_held(c, K_GE, M_REL);
                    CH_DOT:                 start_held(c, K_NUMBER, M_DOT);
                    default: begin
                        if (is_dec(c)) start_held(c, K_NUMBER, M_INT);
                        else if (name_head(c)) start_held(c, K_NAME, M_NAME);
                        else abort(c, E_UNEXP);
                    end
                endcase
            end
        endfunction

        function void report(string what, t_result want, t_result got);
            faults++;
            if (faults <= 10) begin
                $display("%0t %s: expected kind=%0d ch=%02h first=%0b last=%0b line=%0d",
                         $time, what, want.kind, want.ch, want.first, want.last, want.line);
                $display("    fol=%0b err=%0d; got kind=%0d ch=%02h first=%0b last=%0b",
                         want.fol, want.err, got.kind, got.ch, got.first, got.last);
                $display("    line=%0d fol=%0b err=%0d", got.line, got.fol, got.err);
            end
        endfunction

        // One accepted result, checked against the oldest expectation.
        function void match_token(t_result got);
            t_result want;
            if (tokens_due.size() == 0) begin
                report("no result was expected", '0, got);
                return;
            end
            want = tokens_due.pop_front();
            if (got !== want) begin
                report("result mismatch", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_ch;
    logic        i_end_of_text;
    logic        empty;
    logic        pop;
    logic [3:0]  o_token_kind;
    logic [7:0]  o_tok_char;
    logic        o_token_first;
    logic        o_token_last;
    logic [23:0] o_line_number;
    logic        o_first_on_line;
    logic [1:0]  o_error_code;

    token_ledger ledger;

    // Idle percentages of the current phase, and the length of a receiver hold-off that the
    // receiver process counts down on its own.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    // Text waiting to be sent, and whether the last token put into it was a number.
    logic [7:0] text_buf[$];
    bit         after_number;

    // Single-byte punctuation, and bytes that can never start a token.
    logic [7:0] marks[9] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_CARET, CH_SLASH, CH_EQ,
                             CH_LBR, CH_RBR, CH_COLON};
    logic [7:0] odd_marks[8] = '{8'h0B, 8'h0C, 8'h21, 8'h23, 8'h24, 8'h40, 8'h7E, 8'h7F};

    lp_text_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_ch            (i_ch),
        .i_end_of_text   (i_end_of_text),
        .empty           (empty),
        .pop             (pop),
        .o_token_kind    (o_token_kind),
        .o_tok_char      (o_tok_char),
        .o_token_first   (o_token_first),
        .o_token_last    (o_token_last),
        .o_line_number   (o_line_number),
        .o_first_on_line (o_first_on_line),
        .o_error_code    (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both handshakes are observed here, at the rising edge, before the block updates.
    // Results are checked first; they always stem from items accepted at earlier edges.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                ledger.match_token({o_token_kind, o_tok_char, o_token_first, o_token_last,
                                    o_line_number, o_first_on_line, o_error_code});
            end
            if (push && !full) begin
                ledger.take_byte(i_ch, i_end_of_text);
            end
        end
    end

    // Receiver: pops at random according to the phase, except during a hold-off, when it
    // stops popping for the number of cycles that it counts down here.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    // Maps 0..52 onto the bytes that may start a name: a-z, A-Z and underscore.
    function automatic logic [7:0] name_char(int r);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        return CH_UNDER;
    endfunction

    // Appends one byte to the text waiting to be sent.
    function automatic void add_byte(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    // A number in one of its shapes: integer, integer with a fraction (which may be empty),
    // leading dot, or mantissa with an exponent that always carries its digits.
    function automatic void add_number();
        int form;
        int sign;
        form = $urandom_range(3);
        sign = $urandom_range(2);
        if (form != 2) begin
            repeat (1 + $urandom_range(3)) add_byte(digit());
        end
        if (form == 1 || (form == 3 && $urandom_range(1) == 1)) begin
            add_byte(CH_DOT);
            repeat ($urandom_range(3)) add_byte(digit());
        end
        if (form == 2) begin
            add_byte(CH_DOT);
            repeat (1 + $urandom_range(2)) add_byte(digit());
        end
        if (form == 3) begin
            add_byte($urandom_range(1) ? CH_LOW_E : CH_UP_E);
            if (sign == 1) add_byte(CH_PLUS);
            else if (sign == 2) add_byte(CH_MINUS);
            repeat (1 + $urandom_range(1)) add_byte(digit());
        end
    endfunction

    // One random token and the gap after it. The text stays well formed so that the lexer
    // never fails before the end: the only trap is a name starting with e or E right after
    // a number, which would read as an exponent, so a blank is put between the two.
    function automatic void add_token();
        int         pick;
        int         r;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 30) begin
            add_number();
            after_number = 1'b1;
        end else if (pick < 55) begin
            c = name_char($urandom_range(52));
            if (after_number && (c == CH_LOW_E || c == CH_UP_E)) begin
                add_byte(CH_SPACE);
            end
            add_byte(c);
            repeat ($urandom_range(5)) begin
                r = $urandom_range(64);
                if (r < 53) add_byte(name_char(r));
                else if (r < 63) add_byte(digit());
                else add_byte(CH_DOT);
            end
            after_number = 1'b0;
        end else if (pick < 85) begin
            add_byte(marks[$urandom_range(8)]);
            after_number = 1'b0;
        end else begin
            add_byte($urandom_range(1) ? CH_LT : CH_GT);
            if ($urandom_range(1)) add_byte(CH_EQ);
            after_number = 1'b0;
        end

        // Gap: often none at all, so that tokens butt against each other.
        pick = $urandom_range(99);
        if (pick >= 40) begin
            after_number = 1'b0;
        end
        if (pick < 40) begin
        end else if (pick < 62) begin
            add_byte(CH_SPACE);
        end else if (pick < 70) begin
            add_byte(CH_TAB);
        end else if (pick < 78) begin
            add_byte(CH_NL);
        end else if (pick < 84) begin
            add_byte(CH_CR);
            add_byte(CH_NL);
        end else if (pick < 92) begin
            // A comment runs to the end of the line and may hold any other byte.
            add_byte(CH_BSL);
            repeat ($urandom_range(6)) begin
                do c = 8'($urandom_range(255)); while (c == CH_NL);
                add_byte(c);
            end
            add_byte(CH_NL);
        end else begin
            add_byte(CH_SPACE);
            add_byte(CH_NL);
        end
    endfunction

    // Offers one item until it is accepted. Inputs change only at the falling edge, and
    // push is left high so that the next item can follow in the very next cycle.
    task automatic put_byte(input logic [7:0] c, input logic eot);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_ch          <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_buffered();
        while (text_buf.size() != 0) begin
            put_byte(text_buf.pop_front(), 1'b0);
        end
    endtask

    // Lowers push after the last accepted item when the sender stops for a while.
    task automatic hold_input();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // Well-formed random text until the byte budget is spent. With squeeze set, the
    // receiver is told to hold off for a long stretch while the sender keeps going, so
    // the result queue fills and the block stalls its input.
    task automatic send_random(input int budget, input bit squeeze);
        int sent;
        bit squeezed;
        sent     = 0;
        squeezed = 1'b0;
        while (sent < budget) begin
            if (squeeze && !squeezed && sent >= 100) begin
                hold_left = 80;
                squeezed  = 1'b1;
            end
            add_token();
            sent += text_buf.size();
            send_buffered();
        end
    endtask

    // The text ends in one of the ways that stop the lexer for good: the end of text in
    // several states, or an error. A few more items follow, which must give nothing.
    task automatic finish_text();
        int pick;
        int r;
        pick = $urandom_range(8);
        r    = $urandom_range(2);
        add_byte(CH_SPACE);
        case (pick)
            0: ;
            1: add_number();
            2: add_byte($urandom_range(1) ? CH_LT : CH_GT);
            3: begin
                add_byte(digit());
                add_byte(CH_LOW_E);
            end
            4: begin
                add_byte(digit());
                add_byte(CH_UP_E);
                add_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
            end
            5: add_byte(CH_DOT);
            6: begin
                // A leading dot without a digit after it.
                add_byte(CH_DOT);
                add_byte(name_char($urandom_range(52)));
            end
            7: begin
                // An exponent marker without digits.
                add_byte(digit());
                add_byte(CH_LOW_E);
                add_byte(name_char($urandom_range(52)));
            end
            default: begin
                // A byte that cannot start a token: high bytes, low controls, odd marks.
                if (r == 0) add_byte(8'($urandom_range(255, 128)));
                else if (r == 1) add_byte(8'($urandom_range(8)));
                else add_byte(odd_marks[$urandom_range(7)]);
            end
        endcase
        send_buffered();
        put_byte(8'($urandom_range(255)), 1'b1);
        repeat (5) put_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Main sequence.
    initial begin
        string opening;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        i_ch           = '0;
        i_end_of_text  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        after_number   = 1'b0;
        ledger         = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: a comment holding the extreme bytes, a name with a dot, the
        // relation pairs and both relations alone, a leading-dot number with a signed
        // exponent, a carriage return and every single-byte punctuation.
        add_byte(CH_BSL);
        add_byte(8'hFF);
        add_byte(CH_NUL);
        add_byte(CH_NL);
        opening = "a.<=.5e+7><\015>=+-*^/=[]:";
        for (int i = 0; i < opening.len(); i++) add_byte(opening[i]);
        send_buffered();

        // Random phases: no idling, sender idle, receiver stalling, both. Between phases
        // the sender waits until every expected result has come out.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            send_random(375, ph == 0);
            hold_input();
            while (ledger.due() != 0) @(posedge i_clk);
        end

        finish_text();
        hold_input();

        // Drain with a limit, then give the block a few more cycles to show any stray result.
        for (int w = 0; w < 2000 && ledger.due() != 0; w++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        while (ledger.due() != 0) begin
            ledger.report("result never arrived", ledger.tokens_due.pop_front(), '0);
        end

        if (ledger.faults == 0) begin
            $display("lp_text_tokenizer verification clean");
        end else begin
            $display("lp_text_tokenizer verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("lp_text_tokenizer verification failed");
        $finish;
    end

endmodule
